>>> rtl/core/tccc_pkg.sv
`default_nettype none

package tccc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SYN  = 2'd1,
        PH_EST  = 2'd2,
        PH_FIN  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        K_SINGLE = 2'd0,
        K_HSHAKE = 2'd1,
        K_FINACK = 2'd2
    } t_kind;

    localparam logic [1:0] ACT_OPEN = 2'd0;
    localparam logic [1:0] ACT_SEG  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_RETRY   = 2'd1;
    localparam logic [1:0] CFG_REPEAT  = 2'd2;
    localparam logic [1:0] CFG_REQLEN  = 2'd3;

    localparam logic [7:0] FL_FIN    = 8'h01;
    localparam logic [7:0] FL_SYN    = 8'h02;
    localparam logic [7:0] FL_ACK    = 8'h10;
    localparam logic [7:0] FL_SYNACK = 8'h12;
    localparam logic [7:0] FL_PSHACK = 8'h18;
    localparam logic [7:0] FL_FINACK = 8'h11;

    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_WARN    = 3'd1;
    localparam logic [2:0] ST_DONE    = 3'd2;
    localparam logic [2:0] ST_RESTART = 3'd3;
    localparam logic [2:0] ST_FAIL    = 3'd4;

    localparam logic [6:0] IP6_HDR_BYTES = 7'd40;

    typedef struct packed {
        t_kind       kind;
        logic        seg;
        logic [7:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [10:0] plen;
        logic [2:0]  status;
    } t_cmd;

    typedef struct packed {
        logic        seg;
        logic [7:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [10:0] plen;
        logic [2:0]  status;
        logic        last;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/core/tcp_client_connection_controller.sv
// Channel  | Ports                               | Transfer when
// ---------+-------------------------------------+---------------------------
// input    | i_push, o_full, i_action..          | i_push high, o_full low
// result   | o_empty, i_pop, o_has_segment..     | i_pop high, o_empty low
// config   | i_cfg_we, i_cfg_addr, i_cfg_data    | i_cfg_we high
//
// An input item is classified in the cycle it is accepted and leaves at most one
// command in a small queue; the result generator then emits one result per cycle into
// the output register while popped: one for most items, repeat_count+1 for a FIN-ACK
// and 2*(repeat_count+1) for a completed handshake. Input is taken every cycle
// while the queue has room. Reset is synchronous and empties queue and output.
// A pop held low stalls the generator, then the queue fills and o_full rises.
`default_nettype none

module tcp_client_connection_controller #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_initial_seq,
    input  wire logic [7:0]  i_rx_flags,
    input  wire logic [31:0] i_rx_seq,
    input  wire logic [31:0] i_rx_ack,
    input  wire logic [3:0]  i_rx_data_offset,
    input  wire logic [15:0] i_rx_total_length,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic             o_has_segment,
    output logic [7:0]       o_tx_flags,
    output logic [31:0]      o_tx_seq,
    output logic [31:0]      o_tx_ack,
    output logic [10:0]      o_tx_payload_length,
    output logic [2:0]       o_status,
    output logic             o_last,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [10:0] i_cfg_data
);

    logic [7:0]  r_timeout_ticks;
    logic [9:0]  r_retry_limit;
    logic [3:0]  r_repeat_count;
    logic [10:0] r_request_length;

    logic           accept;
    logic           cmd_valid;
    tccc_pkg::t_cmd cmd;
    logic           q_empty;
    logic           q_pop;
    tccc_pkg::t_cmd q_data;
    tccc_pkg::t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks  <= 8'd2;
            r_retry_limit    <= 10'd100;
            r_repeat_count   <= 4'd10;
            r_request_length <= 11'd18;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tccc_pkg::CFG_TIMEOUT: r_timeout_ticks  <= i_cfg_data[7:0];
                tccc_pkg::CFG_RETRY:   r_retry_limit    <= i_cfg_data[9:0];
                tccc_pkg::CFG_REPEAT:  r_repeat_count   <= i_cfg_data[3:0];
                tccc_pkg::CFG_REQLEN:  r_request_length <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign accept = i_push && !o_full;

    tccc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (accept),
        .i_action          (i_action),
        .i_initial_seq     (i_initial_seq),
        .i_rx_flags        (i_rx_flags),
        .i_rx_seq          (i_rx_seq),
        .i_rx_ack          (i_rx_ack),
        .i_rx_data_offset  (i_rx_data_offset),
        .i_rx_total_length (i_rx_total_length),
        .i_timeout_ticks   (r_timeout_ticks),
        .i_retry_limit     (r_retry_limit),
        .i_request_length  (r_request_length),
        .o_cmd_valid       (cmd_valid),
        .o_cmd             (cmd)
    );

    tccc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    tccc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_empty    (q_empty),
        .i_cmd          (q_data),
        .o_cmd_pop      (q_pop),
        .i_repeat_count (r_repeat_count),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_res          (res)
    );

    assign o_has_segment       = res.seg;
    assign o_tx_flags          = res.flags;
    assign o_tx_seq            = res.seq;
    assign o_tx_ack            = res.ack;
    assign o_tx_payload_length = res.plen;
    assign o_status            = res.status;
    assign o_last              = res.last;

endmodule

`default_nettype wire

>>> rtl/core/tccc_front.sv
`default_nettype none

module tccc_front (
    input  wire                logic        i_clk,
    input  wire                logic        i_rst_n,
    input  wire                logic        i_valid,
    input  wire                logic [1:0]  i_action,
    input  wire                logic [31:0] i_initial_seq,
    input  wire                logic [7:0]  i_rx_flags,
    input  wire                logic [31:0] i_rx_seq,
    input  wire                logic [31:0] i_rx_ack,
    input  wire                logic [3:0]  i_rx_data_offset,
    input  wire                logic [15:0] i_rx_total_length,
    input  wire                logic [7:0]  i_timeout_ticks,
    input  wire                logic [9:0]  i_retry_limit,
    input  wire                logic [10:0] i_request_length,
    output logic                            o_cmd_valid,
    output tccc_pkg::t_cmd                  o_cmd
);

    tccc_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_cs, n_cs;
    logic [31:0] r_na, n_na;
    logic [7:0]  r_tsp, n_tsp;
    logic [9:0]  r_rc, n_rc;
    logic        r_ds, n_ds;

    logic [6:0]  hdr;
    logic        has_data;
    logic [15:0] dlen;
    logic [7:0]  tsp_inc;
    logic [9:0]  rc_inc;

    assign hdr      = tccc_pkg::IP6_HDR_BYTES + {1'b0, i_rx_data_offset, 2'b00};
    assign has_data = i_rx_total_length > {9'd0, hdr};
    assign dlen     = i_rx_total_length - {9'd0, hdr};
    assign tsp_inc  = (r_tsp != 8'hFF) ? r_tsp + 8'd1 : r_tsp;
    assign rc_inc   = (r_rc != 10'h3FF) ? r_rc + 10'd1 : r_rc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tccc_pkg::PH_IDLE;
            r_cs    <= '0;
            r_na    <= '0;
            r_tsp   <= '0;
            r_rc    <= '0;
            r_ds    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cs    <= n_cs;
            r_na    <= n_na;
            r_tsp   <= n_tsp;
            r_rc    <= n_rc;
            r_ds    <= n_ds;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_cs         = r_cs;
        n_na         = r_na;
        n_tsp        = r_tsp;
        n_rc         = r_rc;
        n_ds         = r_ds;
        o_cmd_valid  = 1'b0;
        o_cmd        = '0;
        o_cmd.kind   = tccc_pkg::K_SINGLE;
        if (i_valid) begin
            unique case (i_action)
                tccc_pkg::ACT_OPEN: begin
                    n_cs        = i_initial_seq;
                    n_na        = '0;
                    n_tsp       = '0;
                    n_rc        = '0;
                    n_ds        = 1'b0;
                    n_phase     = tccc_pkg::PH_SYN;
                    o_cmd_valid = 1'b1;
                    o_cmd.seg   = 1'b1;
                    o_cmd.flags = tccc_pkg::FL_SYN;
                    o_cmd.seq   = i_initial_seq;
                end
                tccc_pkg::ACT_SEG: begin
                    if (r_phase == tccc_pkg::PH_SYN &&
                        (i_rx_flags & tccc_pkg::FL_SYNACK) == tccc_pkg::FL_SYNACK) begin
                        n_cs         = i_rx_ack + {21'd0, i_request_length};
                        n_na         = i_rx_seq + 32'd1;
                        n_phase      = tccc_pkg::PH_EST;
                        n_tsp        = '0;
                        o_cmd_valid  = 1'b1;
                        o_cmd.kind   = tccc_pkg::K_HSHAKE;
                        o_cmd.seg    = 1'b1;
                        o_cmd.flags  = tccc_pkg::FL_ACK;
                        o_cmd.seq    = i_rx_ack;
                        o_cmd.ack    = i_rx_seq + 32'd1;
                        o_cmd.plen   = i_request_length;
                        o_cmd.status = (i_rx_ack != r_cs + 32'd1) ?
                                       tccc_pkg::ST_WARN : tccc_pkg::ST_NONE;
                    end else if (r_phase == tccc_pkg::PH_EST &&
                                 (i_rx_flags & tccc_pkg::FL_ACK) != 8'd0) begin
                        if (has_data) begin
                            n_ds         = 1'b1;
                            n_na         = i_rx_seq + {16'd0, dlen};
                            o_cmd_valid  = 1'b1;
                            o_cmd.seg    = 1'b1;
                            o_cmd.flags  = tccc_pkg::FL_ACK;
                            o_cmd.seq    = r_cs;
                            o_cmd.ack    = i_rx_seq + {16'd0, dlen};
                            if ((i_rx_flags & tccc_pkg::FL_FIN) != 8'd0) begin
                                n_phase      = tccc_pkg::PH_FIN;
                                o_cmd.status = tccc_pkg::ST_DONE;
                            end
                        end else if ((i_rx_flags & tccc_pkg::FL_FIN) != 8'd0) begin
                            n_na         = i_rx_seq + 32'd1;
                            o_cmd_valid  = 1'b1;
                            o_cmd.kind   = tccc_pkg::K_FINACK;
                            o_cmd.seg    = 1'b1;
                            o_cmd.flags  = tccc_pkg::FL_FINACK;
                            o_cmd.seq    = r_cs;
                            o_cmd.ack    = i_rx_seq + 32'd1;
                            o_cmd.status = r_ds ? tccc_pkg::ST_DONE : tccc_pkg::ST_NONE;
                            if (r_ds) begin
                                n_phase = tccc_pkg::PH_FIN;
                            end
                        end
                    end
                end
                tccc_pkg::ACT_TICK: begin
                    if (r_phase == tccc_pkg::PH_SYN || r_phase == tccc_pkg::PH_EST) begin
                        n_tsp = tsp_inc;
                        if (tsp_inc >= i_timeout_ticks) begin
                            n_tsp = '0;
                            if (r_phase == tccc_pkg::PH_SYN) begin
                                n_phase      = tccc_pkg::PH_IDLE;
                                o_cmd_valid  = 1'b1;
                                o_cmd.status = tccc_pkg::ST_RESTART;
                            end else begin
                                n_rc = rc_inc;
                                if (rc_inc >= i_retry_limit) begin
                                    n_phase      = tccc_pkg::PH_FIN;
                                    o_cmd_valid  = 1'b1;
                                    o_cmd.status = tccc_pkg::ST_FAIL;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tccc_queue.sv
`default_nettype none

module tccc_queue #(
    parameter int DEPTH = 4
) (
    input  wire            logic i_clk,
    input  wire            logic i_rst_n,
    input  wire            logic i_push,
    input  tccc_pkg::t_cmd       i_data,
    output logic                 o_full,
    input  wire            logic i_pop,
    output logic                 o_empty,
    output tccc_pkg::t_cmd       o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tccc_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tccc_back.sv
`default_nettype none

module tccc_back (
    input  wire            logic       i_clk,
    input  wire            logic       i_rst_n,
    input  wire            logic       i_cmd_empty,
    input  tccc_pkg::t_cmd             i_cmd,
    output logic                       o_cmd_pop,
    input  wire            logic [3:0] i_repeat_count,
    output logic                       o_empty,
    input  wire            logic       i_pop,
    output tccc_pkg::t_res             o_res
);

    tccc_pkg::t_cmd r_cmd;
    logic           r_busy;
    logic [4:0]     r_idx;
    tccc_pkg::t_res r_out;
    logic           r_out_valid;

    tccc_pkg::t_res res;
    logic           final_one;
    logic           adv;
    logic           second_half;

    assign adv         = r_busy && (!r_out_valid || i_pop);
    assign second_half = r_idx > {1'b0, i_repeat_count};
    assign o_cmd_pop   = !i_cmd_empty && (!r_busy || (adv && final_one));
    assign o_empty     = !r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        res        = '0;
        res.seg    = r_cmd.seg;
        res.flags  = r_cmd.flags;
        res.seq    = r_cmd.seq;
        res.ack    = r_cmd.ack;
        final_one  = 1'b1;
        unique case (r_cmd.kind)
            tccc_pkg::K_HSHAKE: begin
                final_one = r_idx == {i_repeat_count, 1'b1};
                if (second_half) begin
                    res.flags = tccc_pkg::FL_PSHACK;
                    res.plen  = r_cmd.plen;
                end
                res.status = (r_idx == 5'd0) ? r_cmd.status : tccc_pkg::ST_NONE;
            end
            tccc_pkg::K_FINACK: begin
                final_one  = r_idx == {1'b0, i_repeat_count};
                res.status = final_one ? r_cmd.status : tccc_pkg::ST_NONE;
            end
            default: begin
                res.plen   = r_cmd.plen;
                res.status = r_cmd.status;
            end
        endcase
        res.last = final_one;
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (adv) begin
            r_out <= res;
        end
        if (o_cmd_pop) begin
            r_idx <= '0;
        end else if (adv) begin
            r_idx <= r_idx + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_busy <= 1'b1;
            end else if (adv && final_one) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tccc_chk.sv
`default_nettype none

module tccc_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_empty,
    input wire logic        i_pop,
    input wire logic        o_has_segment,
    input wire logic [7:0]  o_tx_flags,
    input wire logic [31:0] o_tx_seq,
    input wire logic [31:0] o_tx_ack,
    input wire logic [10:0] o_tx_payload_length,
    input wire logic [2:0]  o_status,
    input wire logic        o_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_tx_seq) && $stable(o_tx_ack)
            && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !o_has_segment |-> o_tx_flags == 8'd0 && o_tx_seq == 32'd0
            && o_tx_ack == 32'd0 && o_tx_payload_length == 11'd0 && o_last
            && (o_status == tccc_pkg::ST_RESTART || o_status == tccc_pkg::ST_FAIL))
        else $error("malformed status-only result");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_has_segment |-> o_tx_flags == tccc_pkg::FL_SYN
            || o_tx_flags == tccc_pkg::FL_ACK || o_tx_flags == tccc_pkg::FL_PSHACK
            || o_tx_flags == tccc_pkg::FL_FINACK)
        else $error("illegal segment flags");

    a_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_tx_payload_length != 11'd0 |-> o_tx_flags == tccc_pkg::FL_PSHACK)
        else $error("payload on a segment other than the request");

endmodule

bind tcp_client_connection_controller tccc_chk u_chk (.*);

`default_nettype wire
